// File: rtl/voxel_face_culling_mesher_core_assert.svh
// Assertion macros used by the voxel mesher back end (vfcm_back).
// No dependencies; included inside module bodies.
`ifndef VOXEL_FACE_CULLING_MESHER_CORE_ASSERT_SVH
`define VOXEL_FACE_CULLING_MESHER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VFCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define VFCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/vfcm_pkg.sv
// Types, constants and corner tables for the voxel face-culling mesher.
// No dependencies; imported by every module of the block.
package vfcm_pkg;

	localparam int CHUNK_SIDE_DEF = 16;
	localparam int TYPE_BITS_DEF  = 8;
	localparam int IDX_W          = 18;
	localparam int QUEUE_DEPTH    = 4;
	localparam int NUM_FACES      = 6;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_EMIT  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] vox_x;
		logic [3:0] vox_y;
		logic [3:0] vox_z;
		logic [7:0] voxel_type;
	} item_t;

	typedef struct packed {
		logic [4:0]       pos_x;
		logic [4:0]       pos_y;
		logic [4:0]       pos_z;
		logic [2:0]       face_dir;
		logic [7:0]       face_type;
		logic [IDX_W-1:0] vertex_index;
		logic             is_last;
	} result_t;

	// One entry of the queue: either a counter clear or a voxel to emit.
	typedef struct packed {
		logic                 is_start;
		logic [3:0]           x;
		logic [3:0]           y;
		logic [3:0]           z;
		logic [7:0]           face_type;
		logic [NUM_FACES-1:0] faces;
	} job_t;

	// Corner k (0..3) of a face; corner bits are {dx, dy, dz}.
	function automatic logic [2:0] face_corner(input logic [2:0] face, input logic [1:0] k);
		logic [11:0] row;
		begin
			case (face)
				3'd0: row = {3'd0, 3'd1, 3'd2, 3'd3};
				3'd1: row = {3'd5, 3'd4, 3'd7, 3'd6};
				3'd2: row = {3'd4, 3'd0, 3'd6, 3'd2};
				3'd3: row = {3'd1, 3'd5, 3'd3, 3'd7};
				3'd4: row = {3'd5, 3'd1, 3'd4, 3'd0};
				3'd5: row = {3'd6, 3'd2, 3'd7, 3'd3};
				default: row = '0;
			endcase
			face_corner = row[k*3 +: 3];
		end
	endfunction

	// Two triangles per face: corners 0, 1, 2, 3, 2, 1.
	function automatic logic [1:0] emit_order(input logic [2:0] v);
		begin
			case (v)
				3'd0: emit_order = 2'd0;
				3'd1: emit_order = 2'd1;
				3'd2: emit_order = 2'd2;
				3'd3: emit_order = 2'd3;
				3'd4: emit_order = 2'd2;
				3'd5: emit_order = 2'd1;
				default: emit_order = 2'd0;
			endcase
		end
	endfunction

endpackage

// File: rtl/voxel_face_culling_mesher_core.sv
// Voxel face-culling mesher. Write, start and unused beats, and emit beats outside the chunk, are
// taken and leave busy low unless the job queue is full. An emit beat holds busy while it makes
// seven store reads through one port, captures the last read and, if the voxel is set and has a
// visible face, pushes its job, waiting while the queue is full. The back end gives one vertex
// per cycle, up to 36 per voxel. Reset zeroes the vertex counter and starts a clearing pass over
// all CHUNK_SIDE^3 (4096) cells with busy high; results never stall.
module voxel_face_culling_mesher_core #(
	parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF,
	parameter int TYPE_BITS  = vfcm_pkg::TYPE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  vfcm_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output vfcm_pkg::result_t result
);
	import vfcm_pkg::*;

	job_t push_data;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	vfcm_front #(
		.CHUNK_SIDE(CHUNK_SIDE),
		.TYPE_BITS (TYPE_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.q_full(full),
		.q_push(push),
		.q_data(push_data)
	);

	vfcm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	vfcm_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.strobe(strobe),
		.result(result)
	);

endmodule

// File: rtl/vfcm_fifo.sv
// Short job queue between the classifying front and the emitting back.
// Depends on vfcm_pkg for the job type and depth.
module vfcm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vfcm_pkg::job_t push_data,
	input  logic           pop,
	output vfcm_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import vfcm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/vfcm_front.sv
// Front end: voxel store, clearing pass, item acceptance and neighbour scan.
// Depends on vfcm_pkg; pushes emit and start jobs into vfcm_fifo.
module vfcm_front #(
	parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF,
	parameter int TYPE_BITS  = vfcm_pkg::TYPE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vfcm_pkg::item_t item,
	output logic            busy,
	input  logic            q_full,
	output logic            q_push,
	output vfcm_pkg::job_t  q_data
);
	import vfcm_pkg::*;

	localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [3:0]           x_q, y_q, z_q;
	logic [2:0]           rd_idx_q;
	logic                 rd_vld_s1;
	logic [2:0]           rd_step_s1;
	logic                 rd_inr_s1;
	logic [TYPE_BITS-1:0] rdata_s1;
	logic [TYPE_BITS-1:0] own_q;
	logic [NUM_FACES-1:0] faces_q;

	logic [TYPE_BITS-1:0] mem [CELLS];

	logic                 accept;
	logic                 item_inr;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [TYPE_BITS-1:0] mem_wd;
	logic                 mem_re;
	logic [AW-1:0]        mem_ra;
	logic [4:0]           nx, ny, nz;
	logic                 n_inr;
	logic                 push_emit;
	logic [15:0]          own_wide;

	function automatic logic [AW-1:0] cell_of(input logic [4:0] cx, input logic [4:0] cy,
			input logic [4:0] cz);
		begin
			cell_of = AW'((32'(cz) * CHUNK_SIDE + 32'(cy)) * CHUNK_SIDE + 32'(cx));
		end
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE) || q_full;
	assign item_inr = (32'(item.vox_x) < CHUNK_SIDE) && (32'(item.vox_y) < CHUNK_SIDE) &&
		(32'(item.vox_z) < CHUNK_SIDE);

	// Step 0 reads the voxel itself, steps 1 to 6 its neighbours in face order.
	always_comb begin
		nx    = {1'b0, x_q};
		ny    = {1'b0, y_q};
		nz    = {1'b0, z_q};
		n_inr = 1'b1;
		case (rd_idx_q)
			3'd1: begin
				n_inr = (x_q != 4'd0);
				nx    = {1'b0, x_q} - 5'd1;
			end
			3'd2: begin
				n_inr = (32'(x_q) + 1 < CHUNK_SIDE);
				nx    = {1'b0, x_q} + 5'd1;
			end
			3'd3: begin
				n_inr = (z_q != 4'd0);
				nz    = {1'b0, z_q} - 5'd1;
			end
			3'd4: begin
				n_inr = (32'(z_q) + 1 < CHUNK_SIDE);
				nz    = {1'b0, z_q} + 5'd1;
			end
			3'd5: begin
				n_inr = (y_q != 4'd0);
				ny    = {1'b0, y_q} - 5'd1;
			end
			3'd6: begin
				n_inr = (32'(y_q) + 1 < CHUNK_SIDE);
				ny    = {1'b0, y_q} + 5'd1;
			end
			default: begin
				n_inr = 1'b1;
			end
		endcase
		// Keep the address inside the store when the neighbour lies outside.
		if (!n_inr) begin
			nx = {1'b0, x_q};
			ny = {1'b0, y_q};
			nz = {1'b0, z_q};
		end
	end

	assign mem_re = (state_q == ST_READ) && (rd_idx_q != 3'd7);
	assign mem_ra = cell_of(nx, ny, nz);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_of({1'b0, item.vox_x}, {1'b0, item.vox_y}, {1'b0, item.vox_z});
		mem_wd = TYPE_BITS'(item.voxel_type);
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (accept && item.mode == MODE_WRITE && item_inr) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_ra];
		end
	end

	assign own_wide  = 16'(own_q);
	assign push_emit = (state_q == ST_PUSH) && (own_q != '0) && (faces_q != '0) && !q_full;
	assign q_push    = push_emit || (accept && item.mode == MODE_START);

	always_comb begin
		q_data           = '0;
		q_data.is_start  = !push_emit;
		q_data.x         = x_q;
		q_data.y         = y_q;
		q_data.z         = z_q;
		q_data.face_type = own_wide[7:0];
		q_data.faces     = faces_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= item.vox_x;
			y_q <= item.vox_y;
			z_q <= item.vox_z;
		end
		if (rd_vld_s1) begin
			if (rd_step_s1 == 3'd0) begin
				own_q <= rdata_s1;
			end else begin
				faces_q[rd_step_s1 - 3'd1] <= !rd_inr_s1 || (rdata_s1 == '0);
			end
		end
		if (mem_re) begin
			rd_step_s1 <= rd_idx_q;
			rd_inr_s1  <= n_inr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && item.mode == MODE_EMIT && item_inr) begin
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					if (rd_idx_q == 3'd7) begin
						state_q <= ST_PUSH;
					end else begin
						rd_idx_q <= rd_idx_q + 3'd1;
					end
				end
				ST_PUSH: begin
					if (own_q == '0 || faces_q == '0 || !q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/vfcm_back.sv
// Back end: walks the visible faces of one job and emits a vertex per cycle.
// Depends on vfcm_pkg and the assertion macro header; pops from vfcm_fifo.
module vfcm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  vfcm_pkg::job_t    head,
	input  logic              empty,
	output logic              pop,
	output logic              strobe,
	output vfcm_pkg::result_t result
);
	import vfcm_pkg::*;
	`include "voxel_face_culling_mesher_core_assert.svh"

	job_t                 job_q;
	logic [NUM_FACES-1:0] rem_q;
	logic [2:0]           v_q;
	logic                 act_q;
	logic [IDX_W-1:0]     cnt_q;
	logic                 strobe_q;
	result_t              result_q;

	logic [2:0]           cur_f;
	logic [2:0]           corner;
	logic [NUM_FACES-1:0] rem_next;
	logic                 last_vtx;
	logic                 ending;

	// The lowest remaining face is the one being emitted.
	always_comb begin
		cur_f = 3'd0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				cur_f = 3'(i);
			end
		end
	end

	assign corner   = face_corner(cur_f, emit_order(v_q));
	assign rem_next = rem_q & ~(NUM_FACES'(1) << cur_f);
	assign last_vtx = (v_q == 3'd5);
	assign ending   = act_q && last_vtx && (rem_next == '0);
	assign pop      = !empty && (!act_q || ending);

	assign strobe = strobe_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (act_q) begin
			result_q.pos_x        <= 5'(job_q.x) + 5'(corner[2]);
			result_q.pos_y        <= 5'(job_q.y) + 5'(corner[1]);
			result_q.pos_z        <= 5'(job_q.z) + 5'(corner[0]);
			result_q.face_dir     <= cur_f;
			result_q.face_type    <= job_q.face_type;
			result_q.vertex_index <= cnt_q;
			result_q.is_last      <= ending;
		end
		if (pop && !head.is_start) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			v_q      <= '0;
			act_q    <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_vtx) begin
					v_q   <= '0;
					rem_q <= rem_next;
					if (rem_next == '0) begin
						act_q <= 1'b0;
					end
				end else begin
					v_q <= v_q + 3'd1;
				end
			end
			// A start beat is ordered behind the vertices before it, so it may
			// override the increment of the final vertex.
			if (pop) begin
				if (head.is_start) begin
					cnt_q <= '0;
				end else begin
					rem_q <= head.faces;
					v_q   <= '0;
					act_q <= 1'b1;
				end
			end
		end
	end

	`VFCM_ASSERT_NXT(a_burst_gapless, clk, arst_n, strobe_q && !result_q.is_last, strobe_q,
		"vertices of one voxel are not consecutive")
	`VFCM_ASSERT_NXT(a_index_step, clk, arst_n, strobe_q && !result_q.is_last,
		result_q.vertex_index == $past(result_q.vertex_index) + 1'b1,
		"vertex index skipped within a voxel")
	`VFCM_ASSERT_IMP(a_active_faces, clk, arst_n, act_q, rem_q != '0,
		"emitter active with no faces left")

endmodule

// File: tb/voxel_face_culling_mesher_core_tb.sv
// Self-checking testbench for voxel_face_culling_mesher_core: a directed table,
// then random voxel clusters with emits, all checked against a predictor.
// Depends on vfcm_pkg and the core RTL only.
`timescale 1ns / 100ps

module voxel_face_culling_mesher_core_tb;
	import vfcm_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd3;

	localparam logic [2:0] FACE_NX = 3'd0;

	// Corner bits are {dx, dy, dz}; columns are v0..v3 of each face.
	localparam logic [2:0] FACE_CORNERS [0:5][0:3] = '{
		'{3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd6, 3'd7, 3'd4, 3'd5},
		'{3'd2, 3'd6, 3'd0, 3'd4},
		'{3'd7, 3'd3, 3'd5, 3'd1},
		'{3'd0, 3'd4, 3'd1, 3'd5},
		'{3'd3, 3'd7, 3'd2, 3'd6}
	};
	localparam int TRI_ORDER [0:5] = '{0, 1, 2, 3, 2, 1};
	localparam int NB_DX [0:5] = '{-1, 1, 0, 0, 0, 0};
	localparam int NB_DY [0:5] = '{0, 0, 0, 0, -1, 1};
	localparam int NB_DZ [0:5] = '{0, 0, -1, 1, 0, 0};

	localparam int RAND_BEATS  = 76;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t first_vtx;
	} dir_row_t;

	localparam int N_DIRECTED = 24;
	localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
		'{'{MODE_EMIT, 4'd0, 4'd0, 4'd0, 8'd0}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd0, 4'd0, 4'd0, 8'd1}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd0, 4'd0, 4'd0, 8'd0}, 1'b1,
			'{5'd0, 5'd1, 5'd1, FACE_NX, 8'd1, 18'd0, 1'b0}},
		'{'{MODE_WRITE, 4'd15, 4'd15, 4'd15, 8'd255}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b1,
			'{5'd15, 5'd16, 5'd16, FACE_NX, 8'd255, 18'd36, 1'b0}},
		'{'{MODE_START, 4'd0, 4'd0, 4'd0, 8'd0}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b1,
			'{5'd15, 5'd16, 5'd16, FACE_NX, 8'd255, 18'd0, 1'b0}},
		'{'{MODE_IDLE, 4'd15, 4'd15, 4'd15, 8'd255}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd14, 4'd15, 4'd15, 8'd7}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd14, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd15, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd14, 4'd15, 4'd15, 8'd0}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd8, 4'd8, 4'd8, 8'h80}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd7, 4'd8, 4'd8, 8'h01}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd9, 4'd8, 4'd8, 8'h02}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd8, 4'd8, 4'd7, 8'h04}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd8, 4'd8, 4'd9, 8'h08}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd8, 4'd7, 4'd8, 8'h10}, 1'b0, '0},
		'{'{MODE_WRITE, 4'd8, 4'd9, 4'd8, 8'h20}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd8, 4'd8, 4'd8, 8'd0}, 1'b0, '0},
		'{'{MODE_EMIT, 4'd7, 4'd8, 4'd8, 8'd0}, 1'b0, '0}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	logic [7:0]       voxel_mem [0:4095];
	logic [IDX_W-1:0] vtx_count;
	result_t          vertex_q [$];
	logic [11:0]      filled_q [$];
	int               n_beats = 0;
	int               n_vertices = 0;
	int               n_err = 0;
	bit               idle_on = 1'b1;

	voxel_face_culling_mesher_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic occupied(input int x, input int y, input int z);
		if (x < 0 || y < 0 || z < 0 || x > 15 || y > 15 || z > 15)
			return 1'b0;
		return voxel_mem[{z[3:0], y[3:0], x[3:0]}] != 8'd0;
	endfunction

	// Updates the store and counter for one beat and queues the vertices it yields.
	task automatic mesh_predict(input item_t it, output int first);
		logic [7:0] own;
		logic [2:0] c;
		result_t    v;
		first = vertex_q.size();
		case (it.mode)
			MODE_START: begin
				vtx_count = '0;
			end
			MODE_WRITE: begin
				voxel_mem[{it.vox_z, it.vox_y, it.vox_x}] = it.voxel_type;
			end
			MODE_EMIT: begin
				own = voxel_mem[{it.vox_z, it.vox_y, it.vox_x}];
				if (own != 8'd0) begin
					for (int f = 0; f < 6; f++) begin
						if (!occupied(int'(it.vox_x) + NB_DX[f], int'(it.vox_y) + NB_DY[f],
								int'(it.vox_z) + NB_DZ[f])) begin
							for (int k = 0; k < 6; k++) begin
								c = FACE_CORNERS[f][TRI_ORDER[k]];
								v.pos_x        = {1'b0, it.vox_x} + 5'(c[2]);
								v.pos_y        = {1'b0, it.vox_y} + 5'(c[1]);
								v.pos_z        = {1'b0, it.vox_z} + 5'(c[0]);
								v.face_dir     = 3'(f);
								v.face_type    = own;
								v.vertex_index = vtx_count;
								v.is_last      = 1'b0;
								vertex_q.insert(vertex_q.size(), v);
								vtx_count = vtx_count + 1'b1;
							end
						end
					end
					if (vertex_q.size() > first)
						vertex_q[vertex_q.size() - 1].is_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Holds the beat until it is taken, then predicts it and idles for the given gap.
	task automatic drive_beat(input item_t it, input logic typed, input result_t first_vtx,
			input int gap);
		int base;
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		mesh_predict(it, base);
		if (typed && vertex_q.size() > base)
			vertex_q[base] = first_vtx;
		n_beats++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic report(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (vertex_q.size() == 0) begin
				$display("%0t: vertex expected none, got index %0d", $time,
					result.vertex_index);
				n_err++;
			end else begin
				want = vertex_q.pop_front();
				report("pos_x", int'(want.pos_x), int'(result.pos_x));
				report("pos_y", int'(want.pos_y), int'(result.pos_y));
				report("pos_z", int'(want.pos_z), int'(result.pos_z));
				report("face_dir", int'(want.face_dir), int'(result.face_dir));
				report("face_type", int'(want.face_type), int'(result.face_type));
				report("vertex_index", int'(want.vertex_index), int'(result.vertex_index));
				report("is_last", int'(want.is_last), int'(result.is_last));
				n_vertices++;
			end
		end
	end

	initial begin
		item_t      it;
		int         r;
		int         n_rand;
		logic [3:0] bx, by, bz;
		logic [11:0] pick_addr;
		for (int i = 0; i < 4096; i++)
			voxel_mem[i] = 8'd0;
		vtx_count = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			drive_beat(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].first_vtx, pick_gap());

		// Random clusters: writes and emits concentrate round a base that moves now
		// and then, often onto the chunk boundary, so that neighbours really meet.
		n_rand = 0;
		bx = 4'd0;
		by = 4'd0;
		bz = 4'd0;
		while (n_rand < RAND_BEATS) begin
			if (n_rand % 20 == 0) begin
				bx = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1) * 13)
					: 4'($urandom_range(0, 13));
				by = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1) * 13)
					: 4'($urandom_range(0, 13));
				bz = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1) * 13)
					: 4'($urandom_range(0, 13));
			end
			if (n_rand % 25 == 0)
				idle_on = $urandom_range(0, 2) != 0;
			it.vox_x      = bx + 4'($urandom_range(0, 2));
			it.vox_y      = by + 4'($urandom_range(0, 2));
			it.vox_z      = bz + 4'($urandom_range(0, 2));
			it.voxel_type = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 40) begin
				it.mode = MODE_WRITE;
				if ($urandom_range(0, 7) == 0)
					it.voxel_type = 8'd0;
				else if (it.voxel_type == 8'd0)
					it.voxel_type = 8'd1;
				filled_q.insert(filled_q.size(), {it.vox_z, it.vox_y, it.vox_x});
			end else if (r < 85) begin
				it.mode = MODE_EMIT;
				if (filled_q.size() > 0 && $urandom_range(0, 3) != 0) begin
					pick_addr = filled_q[$urandom_range(0, filled_q.size() - 1)];
					{it.vox_z, it.vox_y, it.vox_x} = pick_addr;
				end
			end else if (r < 92) begin
				it.mode = MODE_START;
				{it.vox_z, it.vox_y, it.vox_x} = 12'($urandom);
			end else begin
				it.mode = MODE_IDLE;
				{it.vox_z, it.vox_y, it.vox_x} = 12'($urandom);
			end
			drive_beat(it, 1'b0, '0, pick_gap());
			if (it.mode != MODE_IDLE)
				n_rand++;
		end

		@(negedge clk);
		start <= 1'b0;
		while (vertex_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d beats (directed table, then random clusters).", n_beats);
		$display("Checked %0d vertices field by field; %0d errors.", n_vertices, n_err);
		if (n_err == 0)
			$display("voxel_face_culling_mesher_core: match");
		else
			$display("voxel_face_culling_mesher_core: mismatch");
		$finish;
	end

	// The timeout leaves room for a full run, clearing pass included, even when
	// every emit yields 36 vertices behind the longest gaps.
	initial begin
		#2_000_000;
		$display("Timed out with %0d vertices outstanding.", vertex_q.size());
		$display("voxel_face_culling_mesher_core: mismatch");
		$finish;
	end

endmodule

// File: voxel_face_culling_mesher_core.f
+incdir+rtl
rtl/vfcm_pkg.sv
rtl/vfcm_fifo.sv
rtl/vfcm_front.sv
rtl/vfcm_back.sv
rtl/voxel_face_culling_mesher_core.sv
tb/voxel_face_culling_mesher_core_tb.sv
